// ===== hw/rtl/fos_pkg.sv =====
// ----------------------------------------------------------------------------
// fos_pkg: shared types and constants for flexpage order selection
// Field widths, default parameter values, register codes and the flags that
// travel with each request down the pipeline.
// ----------------------------------------------------------------------------
package fos_pkg;

  localparam int unsigned FIELD_W        = 32;
  localparam int unsigned ORDER_W        = 5;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned CFG_DATA_W     = 32;

  localparam int unsigned DEF_ADDR_WIDTH = 32;
  localparam int unsigned DEF_PAGE_SHIFT = 12;
  localparam int unsigned DEF_MAX_ORDER  = 30;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REGION_BASE = 2'd0,
    CFG_REGION_SIZE = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic valid;
    logic no_hot;
    logic out_of_range;
  } item_flags_t;

endpackage

// ===== hw/rtl/flexpage_order_select_top.sv =====
// Path: a taken request is held in stage A, then stage B, then the order-check
//   register, and out_valid_o rises from the output register; a stalled result side delays it.
// Throughput: one request per cycle; all candidate orders are checked side by
//   side in one stage, so nothing iterates; the stages hold only behind a
//   stalled result.
// Reset: rst_ni clears the stage valid bits at once and sets region_base and
//   region_size to 0; there is no clearing pass.
// ----------------------------------------------------------------------------
// flexpage_order_select_top: largest aligned power-of-two mapping order
// Four-stage pipeline: page rounding, address set-up, parallel order checks,
// order pick with output register. Configuration sits in two registers.
// ----------------------------------------------------------------------------
module flexpage_order_select_top
  import fos_pkg::*;
#(
  parameter int unsigned ADDR_WIDTH = DEF_ADDR_WIDTH,
  parameter int unsigned PAGE_SHIFT = DEF_PAGE_SHIFT,
  parameter int unsigned MAX_ORDER  = DEF_MAX_ORDER
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // request channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [FIELD_W-1:0]    offset_i,
  input  logic [FIELD_W-1:0]    hot_spot_i,
  input  logic [FIELD_W-1:0]    window_low_i,
  input  logic [FIELD_W-1:0]    window_high_i,
  // result channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  status_o,
  output logic [FIELD_W-1:0]    aligned_base_o,
  output logic [ORDER_W-1:0]    map_order_o
);

  localparam int unsigned NumTest = (MAX_ORDER > PAGE_SHIFT) ? MAX_ORDER - PAGE_SHIFT : 1;

  logic [CFG_DATA_W-1:0] region_base_d, region_base_q;
  logic [CFG_DATA_W-1:0] region_size_d, region_size_q;
  logic [ADDR_WIDTH-1:0] cfg_base, cfg_size;

  item_flags_t           flags_b, flags_c;
  logic                  prep_ready, test_ready, pick_ready;
  logic [ADDR_WIDTH-1:0] addr_b, rend_b, hot_b, wlow_b, wend_b, addr_c;
  logic [NumTest-1:0]    pass_c;

  // Configuration: always ready; the user writes only while the pipeline is empty,
  // which the block does not enforce, so later stages read the registers directly. Drop writes beyond the list.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    region_base_d = region_base_q;
    region_size_d = region_size_q;
    if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_REGION_BASE: region_base_d = cfg_data_i;
        CFG_REGION_SIZE: region_size_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_base_q <= '0;
      region_size_q <= '0;
    end else begin
      region_base_q <= region_base_d;
      region_size_q <= region_size_d;
    end
  end

  assign cfg_base = ADDR_WIDTH'(region_base_q);
  assign cfg_size = ADDR_WIDTH'(region_size_q);

  // Hold the request while every stage is full and the result is stalled
  assign in_stall_o = !prep_ready;

  fos_prep #(
    .ADDR_WIDTH (ADDR_WIDTH),
    .PAGE_SHIFT (PAGE_SHIFT)
  ) u_prep (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (prep_ready),
    .offset_i      (offset_i),
    .hot_spot_i    (hot_spot_i),
    .window_low_i  (window_low_i),
    .window_high_i (window_high_i),
    .cfg_base_i    (cfg_base),
    .cfg_size_i    (cfg_size),
    .out_ready_i   (test_ready),
    .flags_o       (flags_b),
    .addr_o        (addr_b),
    .region_end_o  (rend_b),
    .hot_o         (hot_b),
    .wlow_o        (wlow_b),
    .window_end_o  (wend_b)
  );

  fos_order_test #(
    .ADDR_WIDTH (ADDR_WIDTH),
    .PAGE_SHIFT (PAGE_SHIFT),
    .MAX_ORDER  (MAX_ORDER)
  ) u_test (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .flags_i      (flags_b),
    .in_ready_o   (test_ready),
    .addr_i       (addr_b),
    .region_end_i (rend_b),
    .hot_i        (hot_b),
    .wlow_i       (wlow_b),
    .window_end_i (wend_b),
    .cfg_base_i   (cfg_base),
    .out_ready_i  (pick_ready),
    .flags_o      (flags_c),
    .addr_o       (addr_c),
    .pass_o       (pass_c)
  );

  fos_order_pick #(
    .ADDR_WIDTH (ADDR_WIDTH),
    .PAGE_SHIFT (PAGE_SHIFT),
    .MAX_ORDER  (MAX_ORDER)
  ) u_pick (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .flags_i        (flags_c),
    .in_ready_o     (pick_ready),
    .addr_i         (addr_c),
    .pass_i         (pass_c),
    .out_ready_i    (!out_stall_i),
    .valid_o        (out_valid_o),
    .status_o       (status_o),
    .aligned_base_o (aligned_base_o),
    .map_order_o    (map_order_o)
  );

  // A stalled request means the whole pipe is full behind a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("request stalled while the result side could advance");

  // A rejected request carries zero base and order
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> aligned_base_o == '0 && map_order_o == '0)
    else $error("out-of-range result with non-zero fields");

  // An accepted mapping is at least page aligned
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !status_o |-> aligned_base_o[PAGE_SHIFT-1:0] == '0)
    else $error("mapped base not page aligned");

  // An accepted mapping never goes below the page order
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !status_o |->
      (MAX_ORDER > 31) || (map_order_o >= ORDER_W'(PAGE_SHIFT)))
    else $error("mapped order below the page shift");

endmodule

// ===== hw/rtl/fos_prep.sv =====
// ----------------------------------------------------------------------------
// fos_prep: page rounding and address set-up
// Stage A rounds the request fields and the region size to pages; stage B
// forms the range check, the mapped address and the inclusive end addresses.
// ----------------------------------------------------------------------------
module fos_prep
  import fos_pkg::*;
#(
  parameter int unsigned ADDR_WIDTH = DEF_ADDR_WIDTH,
  parameter int unsigned PAGE_SHIFT = DEF_PAGE_SHIFT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [FIELD_W-1:0]    offset_i,
  input  logic [FIELD_W-1:0]    hot_spot_i,
  input  logic [FIELD_W-1:0]    window_low_i,
  input  logic [FIELD_W-1:0]    window_high_i,
  input  logic [ADDR_WIDTH-1:0] cfg_base_i,
  input  logic [ADDR_WIDTH-1:0] cfg_size_i,
  input  logic                  out_ready_i,
  output item_flags_t           flags_o,
  output logic [ADDR_WIDTH-1:0] addr_o,
  output logic [ADDR_WIDTH-1:0] region_end_o,
  output logic [ADDR_WIDTH-1:0] hot_o,
  output logic [ADDR_WIDTH-1:0] wlow_o,
  output logic [ADDR_WIDTH-1:0] window_end_o
);

  localparam logic [ADDR_WIDTH-1:0] PageLow = ~({ADDR_WIDTH{1'b1}} << PAGE_SHIFT);
  localparam logic [ADDR_WIDTH-1:0] One     = ADDR_WIDTH'(1);

  logic                  en_a, en_b;
  item_flags_t           flags_a_d, flags_a_q, flags_b_d, flags_b_q;
  logic [ADDR_WIDTH-1:0] offs_a_q, hot_a_q, wlow_a_q, whigh_a_q, rsize_a_q;
  logic [ADDR_WIDTH-1:0] offs_a_d, hot_a_d, wlow_a_d, whigh_a_d, rsize_a_d;
  logic [ADDR_WIDTH-1:0] addr_b_q, rend_b_q, hot_b_q, wlow_b_q, wend_b_q;
  logic [ADDR_WIDTH-1:0] addr_b_d, rend_b_d, wend_b_d;

  assign en_b       = !flags_b_q.valid || out_ready_i;
  assign en_a       = !flags_a_q.valid || en_b;
  assign in_ready_o = en_a;

  // Stage A: page truncation and round-up
  always_comb begin
    offs_a_d  = ADDR_WIDTH'(offset_i) & ~PageLow;
    hot_a_d   = ADDR_WIDTH'(hot_spot_i) & ~PageLow;
    wlow_a_d  = ADDR_WIDTH'(window_low_i) & ~PageLow;
    whigh_a_d = (ADDR_WIDTH'(window_high_i) + PageLow) & ~PageLow;
    rsize_a_d = (cfg_size_i + PageLow) & ~PageLow;
    flags_a_d.valid        = in_valid_i;
    flags_a_d.no_hot       = (hot_spot_i == {FIELD_W{1'b1}});
    flags_a_d.out_of_range = 1'b0;
  end

  // Stage B: range check and end addresses, all wrapping at the datapath width
  always_comb begin
    addr_b_d  = cfg_base_i + offs_a_q;
    rend_b_d  = cfg_base_i + rsize_a_q - One;
    wend_b_d  = whigh_a_q - One;
    flags_b_d = flags_a_q;
    flags_b_d.out_of_range = (offs_a_q >= rsize_a_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_a_q <= '0;
      flags_b_q <= '0;
    end else begin
      if (en_a) begin
        flags_a_q <= flags_a_d;
      end
      if (en_b) begin
        flags_b_q <= flags_b_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a) begin
      offs_a_q  <= offs_a_d;
      hot_a_q   <= hot_a_d;
      wlow_a_q  <= wlow_a_d;
      whigh_a_q <= whigh_a_d;
      rsize_a_q <= rsize_a_d;
    end
    if (en_b) begin
      addr_b_q <= addr_b_d;
      rend_b_q <= rend_b_d;
      hot_b_q  <= hot_a_q;
      wlow_b_q <= wlow_a_q;
      wend_b_q <= wend_b_d;
    end
  end

  assign flags_o      = flags_b_q;
  assign addr_o       = addr_b_q;
  assign region_end_o = rend_b_q;
  assign hot_o        = hot_b_q;
  assign wlow_o       = wlow_b_q;
  assign window_end_o = wend_b_q;

endmodule

// ===== hw/rtl/fos_order_test.sv =====
// ----------------------------------------------------------------------------
// fos_order_test: parallel checks of every candidate order
// One comparator set per order; bit j says whether growing from
// PAGE_SHIFT+j to PAGE_SHIFT+j+1 keeps all conditions.
// ----------------------------------------------------------------------------
module fos_order_test
  import fos_pkg::*;
#(
  parameter int unsigned ADDR_WIDTH = DEF_ADDR_WIDTH,
  parameter int unsigned PAGE_SHIFT = DEF_PAGE_SHIFT,
  parameter int unsigned MAX_ORDER  = DEF_MAX_ORDER,
  localparam int unsigned NumTest   = (MAX_ORDER > PAGE_SHIFT) ? MAX_ORDER - PAGE_SHIFT : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  item_flags_t           flags_i,
  output logic                  in_ready_o,
  input  logic [ADDR_WIDTH-1:0] addr_i,
  input  logic [ADDR_WIDTH-1:0] region_end_i,
  input  logic [ADDR_WIDTH-1:0] hot_i,
  input  logic [ADDR_WIDTH-1:0] wlow_i,
  input  logic [ADDR_WIDTH-1:0] window_end_i,
  input  logic [ADDR_WIDTH-1:0] cfg_base_i,
  input  logic                  out_ready_i,
  output item_flags_t           flags_o,
  output logic [ADDR_WIDTH-1:0] addr_o,
  output logic [NumTest-1:0]    pass_o
);

  logic                  en;
  item_flags_t           flags_q;
  logic [ADDR_WIDTH-1:0] addr_q;
  logic [NumTest-1:0]    pass_d, pass_q;

  assign en         = !flags_q.valid || out_ready_i;
  assign in_ready_o = en;

  for (genvar j = 0; j < NumTest; j++) begin : g_order
    if (j < int'(MAX_ORDER) - int'(PAGE_SHIFT)) begin : g_live
      // Mask of the doubled block, clipped at the datapath width
      localparam int unsigned Bits = PAGE_SHIFT + 1 + j;
      localparam logic [ADDR_WIDTH-1:0] Low = ~({ADDR_WIDTH{1'b1}} << Bits);
      logic [ADDR_WIDTH-1:0] mb, hb;
      assign mb = addr_i & ~Low;
      assign hb = hot_i & ~Low;
      // mb and hb have clear low bits, so adding Low is an OR
      assign pass_d[j] = (mb >= cfg_base_i) && ((mb | Low) <= region_end_i) &&
                         (hb >= wlow_i) && ((hb | Low) <= window_end_i) &&
                         !flags_i.no_hot && (((addr_i ^ hot_i) & Low) == '0);
    end else begin : g_none
      assign pass_d[j] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else if (en) begin
      flags_q <= flags_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      addr_q <= addr_i;
      pass_q <= pass_d;
    end
  end

  assign flags_o = flags_q;
  assign addr_o  = addr_q;
  assign pass_o  = pass_q;

endmodule

// ===== hw/rtl/fos_order_pick.sv =====
// ----------------------------------------------------------------------------
// fos_order_pick: order selection and output register
// Counts the unbroken run of passing checks from the page order upwards,
// aligns the address to the chosen order and holds the result.
// ----------------------------------------------------------------------------
module fos_order_pick
  import fos_pkg::*;
#(
  parameter int unsigned ADDR_WIDTH = DEF_ADDR_WIDTH,
  parameter int unsigned PAGE_SHIFT = DEF_PAGE_SHIFT,
  parameter int unsigned MAX_ORDER  = DEF_MAX_ORDER,
  localparam int unsigned NumTest   = (MAX_ORDER > PAGE_SHIFT) ? MAX_ORDER - PAGE_SHIFT : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  item_flags_t           flags_i,
  output logic                  in_ready_o,
  input  logic [ADDR_WIDTH-1:0] addr_i,
  input  logic [NumTest-1:0]    pass_i,
  input  logic                  out_ready_i,
  output logic                  valid_o,
  output logic                  status_o,
  output logic [FIELD_W-1:0]    aligned_base_o,
  output logic [ORDER_W-1:0]    map_order_o
);

  localparam int unsigned OrdW = $clog2(MAX_ORDER + 1);
  localparam int unsigned CntW = $clog2(NumTest + 2);

  logic                  en;
  logic                  valid_q, status_q;
  logic [FIELD_W-1:0]    base_d, base_q;
  logic [ORDER_W-1:0]    order_d, order_q;
  logic [NumTest:0]      pass_x, pass_inc, first_zero;
  logic [NumTest-1:0]    run;
  logic [CntW-1:0]       count;
  logic [OrdW-1:0]       order;
  logic [ADDR_WIDTH-1:0] low_mask;

  assign en         = !valid_q || out_ready_i;
  assign in_ready_o = en;

  // First failing check as a one-hot, the passing run below it as a mask
  assign pass_x     = {1'b0, pass_i};
  assign pass_inc   = pass_x + (NumTest+1)'(1);
  assign first_zero = pass_inc & ~pass_x;
  assign run        = pass_i & ~pass_inc[NumTest-1:0];

  always_comb begin
    count = '0;
    for (int i = 0; i <= int'(NumTest); i++) begin
      if (first_zero[i]) begin
        count = count | CntW'(i);
      end
    end
    order = OrdW'(PAGE_SHIFT) + OrdW'(count);
  end

  always_comb begin
    low_mask = '0;
    for (int b = 0; b < int'(ADDR_WIDTH); b++) begin
      if (b < int'(PAGE_SHIFT)) begin
        low_mask[b] = 1'b1;
      end else if (b - int'(PAGE_SHIFT) < int'(NumTest)) begin
        low_mask[b] = run[b - int'(PAGE_SHIFT)];
      end
    end
  end

  always_comb begin
    if (flags_i.out_of_range) begin
      base_d  = '0;
      order_d = '0;
    end else begin
      base_d  = addr_i[FIELD_W-1:0] & ~low_mask[FIELD_W-1:0];
      order_d = order[ORDER_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= flags_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      status_q <= flags_i.out_of_range;
      base_q   <= base_d;
      order_q  <= order_d;
    end
  end

  assign valid_o        = valid_q;
  assign status_o       = status_q;
  assign aligned_base_o = base_q;
  assign map_order_o    = order_q;

endmodule

// ===== dv/fos_map_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fos_map_checker: scoreboard for flexpage order selection
// Tracks the two region registers from the configuration channel, predicts
// the mapping for every accepted request and compares each accepted result
// against the oldest prediction.
// ----------------------------------------------------------------------------
module fos_map_checker
  import fos_pkg::*;
#(
  parameter int unsigned PAGE_SHIFT = DEF_PAGE_SHIFT,
  parameter int unsigned MAX_ORDER  = DEF_MAX_ORDER
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic [FIELD_W-1:0]    offset_i,
  input  logic [FIELD_W-1:0]    hot_spot_i,
  input  logic [FIELD_W-1:0]    window_low_i,
  input  logic [FIELD_W-1:0]    window_high_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic                  status_i,
  input  logic [FIELD_W-1:0]    aligned_base_i,
  input  logic [ORDER_W-1:0]    map_order_i,
  output int unsigned           mismatches_o,
  output int unsigned           pending_o,
  output int unsigned           results_o,
  output int unsigned           rejected_o,
  output int unsigned           deepest_order_o
);

  typedef struct packed {
    logic               status;
    logic [FIELD_W-1:0] base;
    logic [ORDER_W-1:0] order;
  } mapping_t;

  localparam logic [FIELD_W-1:0] PAGE_LOW = (FIELD_W'(1) << PAGE_SHIFT) - 1;

  logic [FIELD_W-1:0] region_base_q;
  logic [FIELD_W-1:0] region_size_q;
  mapping_t           expected_maps[$];
  int unsigned        mismatch_total;
  int unsigned        result_total;
  int unsigned        rejected_total;
  int unsigned        deepest_order;

  assign mismatches_o    = mismatch_total;
  assign results_o       = result_total;
  assign rejected_o      = rejected_total;
  assign deepest_order_o = deepest_order;

  // Largest aligned block around region_base+offset that fits the region,
  // the receive window and the hot spot alignment.
  function automatic mapping_t pick_mapping(input logic [FIELD_W-1:0] offs_raw,
                                            input logic [FIELD_W-1:0] hot_raw,
                                            input logic [FIELD_W-1:0] wlow_raw,
                                            input logic [FIELD_W-1:0] whigh_raw);
    logic [FIELD_W-1:0] offs, hot, wlow, whigh, rsize;
    logic [FIELD_W-1:0] addr, region_end, window_end, low, mb, hb;
    int unsigned        order;
    logic               grow;
    mapping_t           m;
    offs  = offs_raw & ~PAGE_LOW;
    hot   = hot_raw & ~PAGE_LOW;
    wlow  = wlow_raw & ~PAGE_LOW;
    whigh = (whigh_raw + PAGE_LOW) & ~PAGE_LOW;
    rsize = (region_size_q + PAGE_LOW) & ~PAGE_LOW;
    m     = '0;
    if (offs >= rsize) begin
      m.status = 1'b1;
    end else begin
      addr       = region_base_q + offs;
      region_end = region_base_q + rsize - 1;
      window_end = whigh - 1;
      order      = PAGE_SHIFT;
      grow       = 1'b1;
      while (grow && order < MAX_ORDER) begin
        low = (FIELD_W'(1) << (order + 1)) - 1;
        mb  = addr & ~low;
        hb  = hot & ~low;
        if (mb < region_base_q || FIELD_W'(mb + low) > region_end ||
            hb < wlow || FIELD_W'(hb + low) > window_end ||
            hot_raw == '1 || ((addr ^ hot) & low) != '0) begin
          grow = 1'b0;
        end else begin
          order++;
        end
      end
      m.base  = addr & ~((FIELD_W'(1) << order) - 1);
      m.order = order[ORDER_W-1:0];
    end
    return m;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    mapping_t seen;
    mapping_t want;
    if (!rst_ni) begin
      region_base_q <= '0;
      region_size_q <= '0;
      pending_o     <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_reg_e'(cfg_index_i))
          CFG_REGION_BASE: region_base_q <= cfg_data_i;
          CFG_REGION_SIZE: region_size_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        seen = '{status: status_i, base: aligned_base_i, order: map_order_i};
        result_total++;
        if (expected_maps.size() == 0) begin
          mismatch_total++;
          $display("%0t: result expected none, got status %0d base %h order %0d",
                   $time, seen.status, seen.base, seen.order);
        end else begin
          want = expected_maps.pop_front();
          if (seen.status !== want.status)
            $display("%0t: status expected %0d, got %0d", $time, want.status, seen.status);
          if (seen.base !== want.base)
            $display("%0t: aligned_base expected %h, got %h", $time, want.base,
                     seen.base);
          if (seen.order !== want.order)
            $display("%0t: map_order expected %0d, got %0d", $time, want.order, seen.order);
          if (seen !== want) mismatch_total++;
          if (want.status) rejected_total++;
          else if (want.order > deepest_order) deepest_order = want.order;
        end
      end
      if (in_valid_i && !in_stall_i)
        expected_maps.push_back(pick_mapping(offset_i, hot_spot_i, window_low_i,
                                             window_high_i));
      pending_o <= expected_maps.size();
    end
  end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: flexpage order selection
// Writes region settings between phases, sends directed corner requests and
// then random phases of mostly well-formed mappings, with random idle bursts
// on both channels. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
  import fos_pkg::*;

  localparam int unsigned       WATCHDOG_LIMIT  = 1000;
  localparam int unsigned       SETTLE_CYCLES   = 8;
  localparam int unsigned       RANDOM_PHASES   = 8;
  localparam int unsigned       PHASE_REQUESTS  = 50;
  localparam logic [FIELD_W-1:0] PAGE_LOW = (FIELD_W'(1) << DEF_PAGE_SHIFT) - 1;

  logic                  clk_i;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = CFG_REGION_BASE;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                  in_valid_i    = 1'b0;
  logic                  in_stall_o;
  logic [FIELD_W-1:0]    offset_i      = '0;
  logic [FIELD_W-1:0]    hot_spot_i    = '0;
  logic [FIELD_W-1:0]    window_low_i  = '0;
  logic [FIELD_W-1:0]    window_high_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i   = 1'b0;
  logic                  status_o;
  logic [FIELD_W-1:0]    aligned_base_o;
  logic [ORDER_W-1:0]    map_order_o;

  int unsigned mismatches, pending_maps, results_seen, rejected_seen, deepest_order;

  // Region as last written, used to aim random offsets inside the region.
  logic [FIELD_W-1:0] region_base_now = '0;
  logic [FIELD_W-1:0] region_size_now = '0;
  int unsigned        requests_sent   = 0;
  int unsigned        settings_used   = 0;
  // Odds of an idle burst per request / per cycle: one in N, none when 0.
  int unsigned        gap_odds        = 0;
  int unsigned        stall_odds      = 0;

  flexpage_order_select_top i_dut (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i,
    .in_valid_i,
    .in_stall_o,
    .offset_i,
    .hot_spot_i,
    .window_low_i,
    .window_high_i,
    .out_valid_o,
    .out_stall_i,
    .status_o,
    .aligned_base_o,
    .map_order_o
  );

  fos_map_checker i_checker (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_i     (cfg_ready_o),
    .cfg_index_i,
    .cfg_data_i,
    .in_valid_i,
    .in_stall_i      (in_stall_o),
    .offset_i,
    .hot_spot_i,
    .window_low_i,
    .window_high_i,
    .out_valid_i     (out_valid_o),
    .out_stall_i,
    .status_i        (status_o),
    .aligned_base_i  (aligned_base_o),
    .map_order_i     (map_order_o),
    .mismatches_o    (mismatches),
    .pending_o       (pending_maps),
    .results_o       (results_seen),
    .rejected_o      (rejected_seen),
    .deepest_order_o (deepest_order)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Result side: stall in random bursts while enabled.
  initial begin
    forever begin
      @(posedge clk_i);
      if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
    end
  end

  // Abort when no handshake of any kind completes for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o))
        quiet = 0;
      else
        quiet++;
    end
    $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
    $display("flexpage_order_select_top: mismatch");
    $finish;
  end

  // Hold a request until it is taken; optionally idle before presenting it.
  task automatic send_request(input logic [FIELD_W-1:0] off, input logic [FIELD_W-1:0] hot,
                              input logic [FIELD_W-1:0] wl, input logic [FIELD_W-1:0] wh);
    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    offset_i      <= off;
    hot_spot_i    <= hot;
    window_low_i  <= wl;
    window_high_i <= wh;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    requests_sent++;
  endtask

  // Drop valid and wait until every predicted result has come out, then
  // let the pipeline settle before touching the registers.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_maps != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] val);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_region(input logic [FIELD_W-1:0] base, input logic [FIELD_W-1:0] size);
    write_reg(CFG_REGION_BASE, base);
    write_reg(CFG_REGION_SIZE, size);
    region_base_now = base;
    region_size_now = size;
    settings_used++;
  endtask

  // Pick a region: mostly a power-of-two size on a base aligned to it, so
  // that deep orders are reachable; now and then an empty, wrapping,
  // unaligned or arbitrary one.
  task automatic pick_region();
    logic [FIELD_W-1:0] base, size;
    int unsigned        ks;
    ks   = $urandom_range(DEF_PAGE_SHIFT, 31);
    size = FIELD_W'(1) << ks;
    case ($urandom_range(0, 11))
      0: size = '0;
      1: size = '1;
      2: size = $urandom;
      3: size = $urandom_range(1, 32'h0004_0000);
      4: size = size - $urandom_range(0, PAGE_LOW);
      default: ;
    endcase
    case ($urandom_range(0, 7))
      0: base = '0;
      1: base = $urandom;
      2: base = $urandom & ~PAGE_LOW;
      default: base = $urandom & ~((FIELD_W'(1) << ks) - 1);
    endcase
    set_region(base, size);
  endtask

  // Mostly well-formed requests: offset inside the region, a hot spot that
  // shares the low address bits, a window aligned around the hot spot.
  // The rest is raw noise and offsets just past the region end.
  task automatic random_request();
    logic [FIELD_W-1:0] rsize, off, addr, hot, wl, wh, mask;
    int unsigned        k, j;
    rsize = (region_size_now + PAGE_LOW) & ~PAGE_LOW;
    if ($urandom_range(0, 9) < 7) begin
      off  = (rsize == '0) ? FIELD_W'($urandom) : FIELD_W'($urandom) % rsize;
      addr = region_base_now + (off & ~PAGE_LOW);
      k    = $urandom_range(DEF_PAGE_SHIFT, 31);
      mask = (FIELD_W'(1) << k) - 1;
      hot  = ($urandom & ~mask) | (addr & mask & ~PAGE_LOW) | ($urandom & PAGE_LOW);
      if ($urandom_range(0, 9) == 0) hot = '1;
      j = $urandom_range(DEF_PAGE_SHIFT, 32);
      if (j == 32) begin
        wl = '0;
        wh = '0;
      end else begin
        wl = hot & ~((FIELD_W'(1) << j) - 1);
        wh = wl + (FIELD_W'(1) << j);
      end
      // shrink the window by a page now and then to cap the order
      if ($urandom_range(0, 3) == 0) wh = wh - (PAGE_LOW + 1);
      wl = wl | ($urandom & PAGE_LOW);
      wh = wh - $urandom_range(0, PAGE_LOW);
    end else begin
      off = $urandom;
      hot = $urandom;
      wl  = $urandom;
      wh  = $urandom;
      if ($urandom_range(0, 1) == 1) off = rsize + $urandom_range(0, 32'h0000_FFFF);
    end
    send_request(off, hot, wl, wh);
  endtask

  initial begin : stimulus
    int unsigned directed_count;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    gap_odds   = 4;
    stall_odds = 4;

    // Registers at reset: empty region, so everything is out of range.
    send_request('0, '0, '0, '0);
    send_request('1, '1, '1, '1);

    // 1 GiB region at address zero.
    set_region('0, 32'h4000_0000);
    // whole window (end rounds to zero): grow all the way to the top order
    send_request('0, '0, '0, '0);
    // no hot spot: stay at the page order
    send_request('0, '1, '0, '0);
    send_request(32'h3FFF_FFFF, 32'h3FFF_F123, '0, '0);
    // first offset past the region end
    send_request(32'h4000_0000, '0, '0, '0);
    send_request(32'h0000_0FFF, 32'hFFFF_E000, 32'hFFFF_E000, '0);
    send_request(32'h0010_0000, 32'h8010_0000, 32'h8000_0000, 32'h8020_0000);
    // window low end with stray low bits: truncate low; the high end is page aligned
    send_request(32'h0000_3000, 32'h1000_3000, 32'h1000_3001, 32'h1000_4000);
    // hot spot one below all ones is a real hot spot
    send_request(32'h2000_0000, 32'hFFFF_FFFE, '0, '0);
    // inverted window
    send_request('0, '0, 32'hFFFF_FFFF, 32'h0000_0001);

    // Size rounds up past the top and wraps to zero: reject every offset.
    set_region(32'hFFFF_F000, '1);
    send_request('0, '0, '0, '0);

    // Single page.
    set_region(32'h8000_0000, 32'h0000_0001);
    send_request('0, 32'h8000_0000, '0, '0);
    send_request(32'h0000_0FFF, 32'h8000_0FFF, '0, '0);
    send_request(32'h0000_1000, 32'h8000_1000, '0, '0);

    // Largest region that does not wrap.
    set_region('0, 32'hFFFF_F000);
    send_request(32'hFFFF_EFFF, 32'hFFFF_E000, '0, '0);
    // order capped at the maximum
    send_request(32'h4000_0000, 32'h4000_0000, '0, '0);

    // Base off the page grid is used as given.
    set_region(32'h0000_1234, 32'h0001_0000);
    send_request('0, 32'h0000_1234, '0, '0);
    send_request(32'h0000_8000, '1, '1, '1);
    directed_count = requests_sent;

    // Random phases: a fresh region each, varying idle pressure; the first
    // phase and the last one run without idling.
    for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
      pick_region();
      if (p == 0 || p == RANDOM_PHASES - 1) begin
        gap_odds   = 0;
        stall_odds = 0;
      end else begin
        gap_odds   = $urandom_range(2, 8);
        stall_odds = $urandom_range(2, 8);
      end
      repeat (PHASE_REQUESTS) random_request();
    end

    wait_idle();

    $display("summary: %0d requests (%0d directed) over %0d region settings",
             requests_sent, directed_count, settings_used);
    $display("summary: %0d results, %0d out of range, deepest order %0d",
             results_seen, rejected_seen, deepest_order);
    if (mismatches == 0 && pending_maps == 0) begin
      $display("flexpage_order_select_top: match");
    end else begin
      $display("flexpage_order_select_top: mismatch");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/fos_pkg.sv
hw/rtl/fos_prep.sv
hw/rtl/fos_order_test.sv
hw/rtl/fos_order_pick.sv
hw/rtl/flexpage_order_select_top.sv
dv/fos_map_checker.sv
dv/testbench.sv
